>>> design/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared widths and constants for the pure pursuit steering block
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int POS_W   = 32;
  localparam int SPD_W   = 16;
  localparam int QUAT_W  = 16;
  localparam int LA_W    = 24;
  localparam int RATE_W  = 15;
  localparam int PLEN_W  = 9;
  localparam int SLOT_W  = 8;
  localparam int CFG_W   = 24;
  localparam int CIDX_W  = 2;

  localparam int WORK_W  = 36;
  localparam int MB_W    = 25;
  localparam int PROD_W  = WORK_W + MB_W;
  localparam int LSQ_W   = 2 * LA_W;
  localparam int SQ_W    = LSQ_W + 2;
  localparam int REM_W   = 64;
  localparam int DIV_STEPS = 32;
  localparam int QUO_W   = 32;

  localparam logic [LA_W-1:0]   INV_GAIN_Q24 = 24'd10188014;
  localparam logic [WORK_W-1:0] ONE_Q28      = 36'd268435456;

  localparam logic [CIDX_W-1:0] REG_LOOKAHEAD = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MAX_RATE  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_PATH_LEN  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ODOM = 1'b1;

endpackage

`default_nettype wire

>>> design/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// pure pursuit path tracker: waypoint store, lookahead walk, cordic heading,
// robot-frame rotation and curvature division on one shared datapath
// ----------------------------------------------------------------------------
// channel   direction  handshake          word
// input     in         start / busy       operation, slot, pose, quaternion
// result    out        done (strobe)      linear, angular velocity, stopped
// config    in         cfg_write          cfg_index, cfg_data
//
// a load word is written into the waypoint store without making the block busy;
// the length of an odometry word is set by the waypoint walk, the cordic
// loop and the 32-step restoring divider.
// busy is high for the whole odometry word; done is a one-cycle strobe.
// synchronous reset clears the index, done and the sequencer and loads the config defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pure_pursuit_steering
  import pps_pkg::*;
#(
  parameter int MAX_WAYPOINTS     = 256,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic                     operation,
  input  wire logic [SLOT_W-1:0]        waypoint_slot,
  input  wire logic signed [POS_W-1:0]  pos_x,
  input  wire logic signed [POS_W-1:0]  pos_y,
  input  wire logic signed [SPD_W-1:0]  waypoint_speed,
  input  wire logic signed [QUAT_W-1:0] quat_x,
  input  wire logic signed [QUAT_W-1:0] quat_y,
  input  wire logic signed [QUAT_W-1:0] quat_z,
  input  wire logic signed [QUAT_W-1:0] quat_w,
  input  wire logic                     cfg_write,
  input  wire logic [CIDX_W-1:0]        cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  output      logic                     done,
  output      logic signed [SPD_W-1:0]  linear_velocity,
  output      logic signed [SPD_W-1:0]  angular_velocity,
  output      logic                     stopped
);

  localparam int AW    = $clog2(MAX_WAYPOINTS);
  localparam int IW    = $clog2(MAX_WAYPOINTS + 1);
  localparam int ENT_W = 2 * POS_W + SPD_W;
  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [18:0] {
    S_IDLE = 19'h00001,
    S_LSQ  = 19'h00002,
    S_RD   = 19'h00004,
    S_DIFF = 19'h00008,
    S_CMP  = 19'h00010,
    S_SQX  = 19'h00020,
    S_SQY  = 19'h00040,
    S_TST  = 19'h00080,
    S_QA   = 19'h00100,
    S_QB   = 19'h00200,
    S_QC   = 19'h00400,
    S_QD   = 19'h00800,
    S_PRE  = 19'h01000,
    S_CORD = 19'h02000,
    S_GAIN = 19'h04000,
    S_NUM  = 19'h08000,
    S_DCHK = 19'h10000,
    S_DIV  = 19'h20000,
    S_OUT  = 19'h40000
  } state_t;

  state_t state;

  logic [LA_W-1:0]   lookahead;
  logic [RATE_W-1:0] max_rate;
  logic [PLEN_W-1:0] path_len;
  logic [IW-1:0]     target_index;
  logic [IW-1:0]     eff_len;

  logic signed [POS_W-1:0]  px, py;
  logic signed [QUAT_W-1:0] qx, qy, qz, qw;

  logic [ENT_W-1:0]  rd_data;
  logic              wr_en;
  logic [ENT_W-1:0]  wr_data;

  logic signed [WORK_W-1:0] dx, dy, c, s, h, yr;
  logic signed [SPD_W-1:0]  speed;
  logic [WORK_W-1:0]        ax, ay;
  logic [LSQ_W-1:0]         lsq;
  logic [SQ_W-1:0]          sq;
  logic [CNT_W-1:0]         cnt;
  logic signed [PROD_W-1:0] num;
  logic                     neg;
  logic [REM_W-1:0]         rem, rem2, dvs, mag_num;
  logic [QUO_W-1:0]         quo;
  logic [RATE_W-1:0]        qclamp;

  logic signed [WORK_W-1:0] ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;

  logic signed [WORK_W-1:0] c_sh, s_sh, x_sh, y_sh;

  // path store
  assign wr_en   = start && !busy && (operation == OP_LOAD)
                   && (32'(waypoint_slot) < 32'(MAX_WAYPOINTS));
  assign wr_data = {pos_x, pos_y, waypoint_speed};

  pps_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WAYPOINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(waypoint_slot)),
    .wr_data (wr_data),
    .rd_addr (target_index[AW-1:0]),
    .rd_data (rd_data)
  );

  assign busy    = (state != S_IDLE);
  assign eff_len = (32'(path_len) > 32'(MAX_WAYPOINTS)) ? IW'(MAX_WAYPOINTS)
                                                        : IW'(path_len);

  assign ax = dx[WORK_W-1] ? WORK_W'(-dx) : WORK_W'(dx);
  assign ay = dy[WORK_W-1] ? WORK_W'(-dy) : WORK_W'(dy);

  assign c_sh = c >>> cnt;
  assign s_sh = s >>> cnt;
  assign x_sh = dx >>> cnt;
  assign y_sh = dy >>> cnt;

  assign dvs     = {1'b0, lsq, 15'b0};
  assign rem2    = {rem[REM_W-2:0], 1'b0};
  assign mag_num = num[PROD_W-1] ? REM_W'(-num) : REM_W'(num);
  assign qclamp  = (quo > QUO_W'(max_rate)) ? max_rate : quo[RATE_W-1:0];

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_LSQ: begin
        ma = WORK_W'(lookahead);
        mb = MB_W'(lookahead);
      end
      S_SQX: begin
        ma = ax;
        mb = MB_W'(ax);
      end
      S_SQY: begin
        ma = ay;
        mb = MB_W'(ay);
      end
      S_QA: begin
        ma = WORK_W'(qw);
        mb = MB_W'(qz);
      end
      S_QB: begin
        ma = WORK_W'(qx);
        mb = MB_W'(qy);
      end
      S_QC: begin
        ma = WORK_W'(qy);
        mb = MB_W'(qy);
      end
      S_QD: begin
        ma = WORK_W'(qz);
        mb = MB_W'(qz);
      end
      S_GAIN: begin
        ma = dy;
        mb = MB_W'(INV_GAIN_Q24);
      end
      S_NUM: begin
        ma = yr;
        mb = MB_W'(speed);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = PROD_W'(ma) * PROD_W'(mb);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LA_W'(65536);
      max_rate  <= RATE_W'(384);
      path_len  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOOKAHEAD: lookahead <= cfg_data[LA_W-1:0];
        REG_MAX_RATE:  max_rate  <= cfg_data[RATE_W-1:0];
        REG_PATH_LEN:  path_len  <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      target_index <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && operation == OP_ODOM) begin
            px    <= pos_x;
            py    <= pos_y;
            qx    <= quat_x;
            qy    <= quat_y;
            qz    <= quat_z;
            qw    <= quat_w;
            state <= S_LSQ;
          end
        end
        S_LSQ: begin
          lsq   <= LSQ_W'(prod);
          state <= S_RD;
        end
        S_RD: begin
          if (target_index < eff_len) begin
            state <= S_DIFF;
          end else begin
            linear_velocity  <= '0;
            angular_velocity <= '0;
            stopped          <= 1'b1;
            done             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_DIFF: begin
          dx    <= WORK_W'($signed(rd_data[ENT_W-1 -: POS_W])) - WORK_W'(px);
          dy    <= WORK_W'($signed(rd_data[SPD_W +: POS_W])) - WORK_W'(py);
          speed <= rd_data[SPD_W-1:0];
          state <= S_CMP;
        end
        S_CMP: begin
          if (ax >= WORK_W'(lookahead) || ay >= WORK_W'(lookahead)) begin
            state <= S_QA;
          end else begin
            state <= S_SQX;
          end
        end
        S_SQX: begin
          sq    <= SQ_W'(prod);
          state <= S_SQY;
        end
        S_SQY: begin
          sq    <= sq + SQ_W'(prod);
          state <= S_TST;
        end
        S_TST: begin
          if (sq >= SQ_W'(lsq)) begin
            state <= S_QA;
          end else begin
            target_index <= target_index + IW'(1);
            state        <= S_RD;
          end
        end
        S_QA: begin
          h     <= WORK_W'(prod);
          state <= S_QB;
        end
        S_QB: begin
          s     <= (h + WORK_W'(prod)) <<< 1;
          state <= S_QC;
        end
        S_QC: begin
          h     <= WORK_W'(prod);
          state <= S_QD;
        end
        S_QD: begin
          c     <= ONE_Q28 - ((h + WORK_W'(prod)) <<< 1);
          state <= S_PRE;
        end
        S_PRE: begin
          cnt <= '0;
          if (c == '0 && s == '0) begin
            yr    <= dy;
            state <= S_NUM;
          end else begin
            if (c < 0) begin
              if (s >= 0) begin
                c  <= s;
                s  <= -c;
                dx <= dy;
                dy <= -dx;
              end else begin
                c  <= -s;
                s  <= c;
                dx <= -dy;
                dy <= dx;
              end
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (s >= 0) begin
            c  <= c + s_sh;
            s  <= s - c_sh;
            dx <= dx + y_sh;
            dy <= dy - x_sh;
          end else begin
            c  <= c - s_sh;
            s  <= s + c_sh;
            dx <= dx - y_sh;
            dy <= dy + x_sh;
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          yr    <= WORK_W'(prod >>> 24);
          state <= S_NUM;
        end
        S_NUM: begin
          num   <= prod;
          state <= S_DCHK;
        end
        S_DCHK: begin
          neg <= num[PROD_W-1];
          cnt <= '0;
          if (num == '0) begin
            quo   <= '0;
            state <= S_OUT;
          end else if (lsq == '0 || mag_num >= dvs) begin
            quo   <= QUO_W'(max_rate);
            state <= S_OUT;
          end else begin
            rem   <= mag_num;
            quo   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem2 >= dvs) begin
            rem <= rem2 - dvs;
            quo <= {quo[QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem2;
            quo <= {quo[QUO_W-2:0], 1'b0};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          linear_velocity  <= speed;
          angular_velocity <= neg ? -SPD_W'(qclamp) : SPD_W'(qclamp);
          stopped          <= 1'b0;
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> design/pps_checker.sv
// ----------------------------------------------------------------------------
// pps_checker
// port-level checks for the pure pursuit steering block
// ----------------------------------------------------------------------------
`default_nettype none

module pps_checker
  import pps_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    start,
  input wire logic                    busy,
  input wire logic                    operation,
  input wire logic                    done,
  input wire logic signed [SPD_W-1:0] linear_velocity,
  input wire logic signed [SPD_W-1:0] angular_velocity,
  input wire logic                    stopped
);

  // a result word only ends an odometry word
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work in progress");

  // stopped words carry zeros
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    (done && stopped) |-> (linear_velocity == '0 && angular_velocity == '0))
    else $error("stopped word not zero");

  // a load word gives no result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_LOAD) |=> !done)
    else $error("result after load word");

  // odometry word makes the block busy
  a_odom_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_ODOM) |=> busy)
    else $error("odometry word not taken");

  // rate never takes the one value outside the symmetric range
  a_rate_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angular_velocity != 16'sh8000))
    else $error("angular rate out of range");

endmodule

bind pure_pursuit_steering pps_checker u_pps_checker (.*);

`default_nettype wire
